// File: rtl/fts_pkg.sv
// Shared types and constants for the fade transition sequencer.
package fts_pkg;

  localparam int REG_W          = 16;
  localparam int DELAY_W        = REG_W + 1;
  localparam int OP_W           = 3;
  localparam int TICK_W         = 10;
  localparam int LEVEL_W        = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int TIME_BITS_DEF  = 16;
  localparam int ALPHA_BITS_DEF = 8;

  localparam logic [REG_W-1:0] FADE_DURATION_RST = REG_W'(500);

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK     = OP_W'(0);
  localparam logic [OP_W-1:0] OP_FADE_IN  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_FADE_OUT = OP_W'(2);
  localparam logic [OP_W-1:0] OP_TRANS    = OP_W'(3);
  localparam logic [OP_W-1:0] OP_TRANS_LV = OP_W'(4);
  localparam logic [OP_W-1:0] OP_CANCEL   = OP_W'(5);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IN_START_DELAY  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_START_DELAY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_HOLD_TIME = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WAIT_TIME = CFG_IDX_W'(4);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIN,
    PH_FOUT,
    PH_TIN,
    PH_TOUT,
    PH_LIN,
    PH_LWAIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADV,
    ST_LOAD,
    ST_DIV,
    ST_RESULT
  } seq_state_t;

endpackage

// File: rtl/fts_cfg_if.sv
// Configuration write channel.
interface fts_cfg_if
  import fts_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/fts_cmd_if.sv
// Command / tick input channel.
interface fts_cmd_if
  import fts_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [TICK_W-1:0]  tick_amount;
  logic [LEVEL_W-1:0] level_id;

  modport source (output valid, output operation, output tick_amount, output level_id,
                  input ready);
  modport sink   (input valid, input operation, input tick_amount, input level_id,
                  output ready);
endinterface

// File: rtl/fts_res_if.sv
// Result output channel.
interface fts_res_if
  import fts_pkg::*;
#(
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ALPHA_BITS-1:0] alpha;
  logic                  layer_visible;
  logic                  busy_res;
  logic                  fade_in_done;
  logic                  fade_out_done;
  logic                  level_go;
  logic [LEVEL_W-1:0]    level_out;

  modport source (output valid, output alpha, output layer_visible, output busy_res,
                  output fade_in_done, output fade_out_done, output level_go,
                  output level_out, input ready);
  modport sink   (input valid, input alpha, input layer_visible, input busy_res,
                  input fade_in_done, input fade_out_done, input level_go,
                  input level_out, output ready);
endinterface

// File: rtl/fade_transition_sequencer.sv
// Top level of the fade transition sequencer.
// Flow: a command passes states EXEC then RESULT; a tick passes EXEC, ADV, then RESULT;
//   a tick inside a running ramp also passes LOAD and DIV between ADV and RESULT.
// The shared divider in DIV produces one alpha bit per cycle. One item is in flight at a
//   time, but a new item is taken while a result waits.
// Reset (rst, synchronous): idle, no fade, alpha 0, registers back to defaults.
module fade_transition_sequencer
  import fts_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  fts_cfg_if.sink  cfg,
  fts_cmd_if.sink  cmd,
  fts_res_if.source res
);

  localparam int CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
  localparam int SUM_W = ((TIME_BITS > TICK_W) ? TIME_BITS : TICK_W) + 1;
  localparam int NUM_W = REG_W + ALPHA_BITS;
  localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
  localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = '1;

  // Configuration registers
  logic [REG_W-1:0] fade_duration;
  logic [REG_W-1:0] in_start_delay;
  logic [REG_W-1:0] out_start_delay;
  logic [REG_W-1:0] black_hold_time;
  logic [REG_W-1:0] level_wait_time;

  // Sequencer state and architectural state
  seq_state_t state, state_next;
  phase_t     phase, phase_next;
  phase_t     queued_phase, queued_phase_next;
  logic [DELAY_W-1:0]    delay_left, delay_left_next;
  logic [TIME_BITS-1:0]  elapsed, elapsed_next;
  logic [ALPHA_BITS-1:0] alpha_level, alpha_level_next;
  logic                  level_pending, level_pending_next;
  logic [LEVEL_W-1:0]    stored_level, stored_level_next;
  logic                  in_pulse, in_pulse_next;
  logic                  out_pulse, out_pulse_next;
  logic                  go_pulse, go_pulse_next;

  // Latched input item
  logic [OP_W-1:0]    op_q;
  logic [TICK_W-1:0]  ms_q;
  logic [LEVEL_W-1:0] lvl_q;

  // Result register
  logic                  res_valid;
  logic [ALPHA_BITS-1:0] res_alpha;
  logic                  res_busy;
  logic                  res_in_done;
  logic                  res_out_done;
  logic                  res_go;
  logic [LEVEL_W-1:0]    res_level;

  logic cmd_fire;
  logic res_load;

  // Shared divider
  logic                  div_start;
  logic                  div_done;
  logic [ALPHA_BITS-1:0] div_quot;
  logic [NUM_W-1:0]      div_num;
  logic [REG_W-1:0]      e_short;

  // Datapath helpers
  logic [REG_W-1:0]     dur;
  logic [DELAY_W-1:0]   dl_dec;
  logic [SUM_W-1:0]     adv_sum;
  logic [TIME_BITS-1:0] adv;
  logic                 ramp_end;
  logic                 wait_end;
  logic                 busy_now;

  // begin-with-delay and begin-ramp requests raised inside the case below
  logic               dly_go;
  phase_t             dly_ph;
  logic [DELAY_W-1:0] dly_val;
  logic               ramp_go;
  phase_t             ramp_ph;

  function automatic logic is_rising(input phase_t p);
    return (p == PH_FIN) || (p == PH_TIN) || (p == PH_LIN);
  endfunction

  function automatic logic is_falling(input phase_t p);
    return (p == PH_FOUT) || (p == PH_TOUT);
  endfunction

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Zero duration behaves as one millisecond
  assign dur = (fade_duration == '0) ? REG_W'(1) : fade_duration;

  assign dl_dec = (delay_left > DELAY_W'(ms_q)) ? delay_left - DELAY_W'(ms_q) : '0;

  // Elapsed time advance, saturating at the top of the time range
  assign adv_sum  = SUM_W'(elapsed) + SUM_W'(ms_q);
  assign adv      = (adv_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(adv_sum);
  assign ramp_end = CMP_W'(adv) >= CMP_W'(dur);
  assign wait_end = CMP_W'(adv) >= CMP_W'(level_wait_time);

  // Divide only runs while elapsed < duration, so elapsed fits a register word and
  // elapsed * ALPHA_MAX < duration << ALPHA_BITS: quotient never needs clamping.
  assign e_short = REG_W'(elapsed);
  assign div_num = {e_short, {ALPHA_BITS{1'b0}}} - NUM_W'(e_short);

  assign busy_now = (phase != PH_IDLE) || (delay_left != '0) || (queued_phase != PH_IDLE);

  fts_div #(
    .DEN_BITS  (REG_W),
    .QUOT_BITS (ALPHA_BITS)
  ) u_fts_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dur),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state and sequencing
  always_comb begin
    state_next         = state;
    phase_next         = phase;
    queued_phase_next  = queued_phase;
    delay_left_next    = delay_left;
    elapsed_next       = elapsed;
    alpha_level_next   = alpha_level;
    level_pending_next = level_pending;
    stored_level_next  = stored_level;
    in_pulse_next      = in_pulse;
    out_pulse_next     = out_pulse;
    go_pulse_next      = go_pulse;
    div_start          = 1'b0;
    res_load           = 1'b0;
    dly_go             = 1'b0;
    dly_ph             = PH_IDLE;
    dly_val            = '0;
    ramp_go            = 1'b0;
    ramp_ph            = PH_IDLE;

    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        in_pulse_next  = 1'b0;
        out_pulse_next = 1'b0;
        go_pulse_next  = 1'b0;
        state_next     = ST_RESULT;
        case (op_q)
          OP_TICK: begin
            // start delay countdown; expiry launches the queued ramp this same tick
            if (delay_left != '0) begin
              delay_left_next = dl_dec;
              if ((dl_dec == '0) && (queued_phase != PH_IDLE)) begin
                queued_phase_next = PH_IDLE;
                ramp_go           = 1'b1;
                ramp_ph           = queued_phase;
              end
            end
            state_next = ST_ADV;
          end
          OP_FADE_IN: begin
            level_pending_next = 1'b0;
            dly_go  = 1'b1;
            dly_ph  = PH_FIN;
            dly_val = DELAY_W'(in_start_delay);
          end
          OP_FADE_OUT: begin
            level_pending_next = 1'b0;
            dly_go  = 1'b1;
            dly_ph  = PH_FOUT;
            dly_val = DELAY_W'(out_start_delay);
          end
          OP_TRANS: begin
            level_pending_next = 1'b0;
            dly_go  = 1'b1;
            dly_ph  = PH_TIN;
            dly_val = DELAY_W'(in_start_delay);
          end
          OP_TRANS_LV: begin
            level_pending_next = 1'b1;
            stored_level_next  = lvl_q;
            dly_go  = 1'b1;
            dly_ph  = PH_LIN;
            dly_val = DELAY_W'(in_start_delay);
          end
          OP_CANCEL: begin
            phase_next         = PH_IDLE;
            queued_phase_next  = PH_IDLE;
            elapsed_next       = '0;
            delay_left_next    = '0;
            level_pending_next = 1'b0;
            alpha_level_next   = '0;
          end
          default: begin
            // undefined codes leave the state alone
          end
        endcase
      end

      ST_ADV: begin
        state_next = ST_RESULT;
        if (is_rising(phase) || is_falling(phase)) begin
          elapsed_next = adv;
          if (ramp_end) begin
            // ramp complete: ratio clamps to full scale (zero for falling ramps)
            alpha_level_next = is_rising(phase) ? ALPHA_MAX : '0;
            case (phase)
              PH_FIN: begin
                phase_next    = PH_IDLE;
                in_pulse_next = 1'b1;
              end
              PH_TIN: begin
                in_pulse_next = 1'b1;
                dly_go  = 1'b1;
                dly_ph  = PH_TOUT;
                dly_val = DELAY_W'(black_hold_time) + DELAY_W'(out_start_delay);
              end
              PH_LIN: begin
                in_pulse_next = 1'b1;
                if (level_wait_time != '0) begin
                  phase_next   = PH_LWAIT;
                  elapsed_next = '0;
                end else begin
                  go_pulse_next = level_pending;
                  phase_next    = PH_IDLE;
                end
              end
              default: begin
                // falling ramps
                phase_next     = PH_IDLE;
                out_pulse_next = 1'b1;
              end
            endcase
          end else begin
            state_next = ST_LOAD;
          end
        end else if (phase == PH_LWAIT) begin
          elapsed_next = adv;
          if (wait_end) begin
            go_pulse_next = level_pending;
            phase_next    = PH_IDLE;
          end
        end
      end

      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          alpha_level_next = is_rising(phase) ? div_quot : ALPHA_MAX - div_quot;
          state_next       = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!res_valid || res.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // start with optional delay
    if (dly_go) begin
      queued_phase_next = PH_IDLE;
      delay_left_next   = '0;
      if (dly_val != '0) begin
        queued_phase_next = dly_ph;
        delay_left_next   = dly_val;
        phase_next        = PH_IDLE;
        elapsed_next      = '0;
      end else begin
        ramp_go = 1'b1;
        ramp_ph = dly_ph;
      end
    end

    // ramp start: falling ramps open fully black, rising ones fully clear
    if (ramp_go) begin
      phase_next   = ramp_ph;
      elapsed_next = '0;
      if (is_falling(ramp_ph)) begin
        alpha_level_next = ALPHA_MAX;
      end else if (is_rising(ramp_ph)) begin
        alpha_level_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Architectural state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_duration   <= FADE_DURATION_RST;
      in_start_delay  <= '0;
      out_start_delay <= '0;
      black_hold_time <= '0;
      level_wait_time <= '0;
      phase           <= PH_IDLE;
      queued_phase    <= PH_IDLE;
      delay_left      <= '0;
      elapsed         <= '0;
      alpha_level     <= '0;
      level_pending   <= 1'b0;
      stored_level    <= '0;
      in_pulse        <= 1'b0;
      out_pulse       <= 1'b0;
      go_pulse        <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_FADE_DURATION:   fade_duration   <= cfg.data;
          REG_IN_START_DELAY:  in_start_delay  <= cfg.data;
          REG_OUT_START_DELAY: out_start_delay <= cfg.data;
          REG_BLACK_HOLD_TIME: black_hold_time <= cfg.data;
          REG_LEVEL_WAIT_TIME: level_wait_time <= cfg.data;
          default: begin
          end
        endcase
      end
      phase         <= phase_next;
      queued_phase  <= queued_phase_next;
      delay_left    <= delay_left_next;
      elapsed       <= elapsed_next;
      alpha_level   <= alpha_level_next;
      level_pending <= level_pending_next;
      stored_level  <= stored_level_next;
      in_pulse      <= in_pulse_next;
      out_pulse     <= out_pulse_next;
      go_pulse      <= go_pulse_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_q  <= cmd.operation;
      ms_q  <= cmd.tick_amount;
      lvl_q <= cmd.level_id;
    end
    if (res_load) begin
      res_alpha    <= alpha_level;
      res_busy     <= busy_now;
      res_in_done  <= in_pulse;
      res_out_done <= out_pulse;
      res_go       <= go_pulse;
      res_level    <= go_pulse ? stored_level : '0;
    end
  end

  assign res.valid         = res_valid;
  assign res.alpha         = res_alpha;
  assign res.layer_visible = (res_alpha != '0);
  assign res.busy_res      = res_busy;
  assign res.fade_in_done  = res_in_done;
  assign res.fade_out_done = res_out_done;
  assign res.level_go      = res_go;
  assign res.level_out     = res_level;

endmodule

// File: rtl/fts_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module fts_div
  import fts_pkg::*;
#(
  parameter int DEN_BITS  = REG_W,
  parameter int QUOT_BITS = ALPHA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DEN_BITS+QUOT_BITS-1:0] num,   // must be below den << QUOT_BITS
  input  logic [DEN_BITS-1:0]           den,
  output logic                          done,
  output logic [QUOT_BITS-1:0]          quot
);

  localparam int CNT_W = $clog2(QUOT_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DEN_BITS-1:0]  rem;
  logic [DEN_BITS-1:0]  dvs;
  logic [QUOT_BITS-1:0] sh;
  logic [DEN_BITS:0]    trial;
  logic [DEN_BITS:0]    diff;
  logic                 ge;

  assign trial = {rem, sh[QUOT_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[DEN_BITS+QUOT_BITS-1:QUOT_BITS];
      sh   <= num[QUOT_BITS-1:0];
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      sh   <= {sh[QUOT_BITS-2:0], 1'b0};
      quot <= {quot[QUOT_BITS-2:0], ge};
    end
  end

endmodule

// File: rtl/fts_checker.sv
// Port-level checker for the fade transition sequencer, bound to the top level.
module fts_checker
  import fts_pkg::*;
#(
  parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [ALPHA_BITS-1:0] alpha,
  input logic                  layer_visible,
  input logic                  busy_res,
  input logic                  fade_in_done,
  input logic                  fade_out_done,
  input logic                  level_go,
  input logic [LEVEL_W-1:0]    level_out
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(alpha) && $stable(level_out) &&
      $stable(level_go) && $stable(busy_res))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("input taken while item in flight");

  a_visible: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> layer_visible == (alpha != '0))
    else $error("layer_visible disagrees with alpha");

  a_level_out: assert property (@(posedge clk) disable iff (rst)
    res_valid && !level_go |-> level_out == '0)
    else $error("level_out set without level_go");

  // level switch ends the sequence and never coincides with a falling ramp end
  a_level_go_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && level_go |-> !busy_res && !fade_out_done)
    else $error("level_go while still busy");

endmodule

bind fade_transition_sequencer fts_checker #(
  .ALPHA_BITS (ALPHA_BITS)
) u_fts_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .alpha         (res.alpha),
  .layer_visible (res.layer_visible),
  .busy_res      (res.busy_res),
  .fade_in_done  (res.fade_in_done),
  .fade_out_done (res.fade_out_done),
  .level_go      (res.level_go),
  .level_out     (res.level_out)
);
